[rtl/isort_pkg.sv]
// isort_pkg: shared types and constants for the insertion sorter.
// Used by isort_cell and insertion_sorter; depends on nothing.
`default_nettype none

package isort_pkg;

   localparam int DEPTH   = 16;  // number of cells in the chain (2..64)
   localparam int KEY_W   = 32;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key_res;
      logic                    last_res;
      logic                    overflow;
   } rsp_type;

   // Contents of one cell.
   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
   } cell_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic                    load;   // insert key this cycle
      logic                    drain;  // shift chain toward cell 0
      logic signed [KEY_W-1:0] key;
   } ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

[rtl/isort_cell.sv]
// isort_cell: one compare-and-shift cell of the sorting chain.
// Depends on isort_pkg.
`default_nettype none

module isort_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire isort_pkg::ctrl_type ctrl,
   input  wire isort_pkg::cell_type prev_cell,  // neighbor toward cell 0
   input  wire logic                prev_move,  // neighbor gives up its slot
   input  wire isort_pkg::cell_type next_cell,  // neighbor away from cell 0
   output isort_pkg::cell_type      slot,
   output logic                     move
);
   import isort_pkg::*;

   logic                    valid_ff, valid_in;
   logic signed [KEY_W-1:0] key_ff, key_in;

   // Slot is displaced by an insert if empty or holding a strictly greater key.
   assign move = !valid_ff || (key_ff > ctrl.key);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      if (ctrl.load) begin
         if (move) begin
            if (prev_move) begin
               valid_in = prev_cell.valid;
               key_in   = prev_cell.key;
            end else begin
               valid_in = 1'b1;
               key_in   = ctrl.key;
            end
         end
      end else if (ctrl.drain) begin
         valid_in = next_cell.valid;
         key_in   = next_cell.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign slot.valid = valid_ff;
   assign slot.key   = key_ff;

endmodule

`default_nettype wire

[rtl/insertion_sorter.sv]
// insertion_sorter: stable ascending sorter over a chain of DEPTH cells.
// Output: a set's words come out on the DEPTH-cell chain one per cycle,
// starting the cycle after the word flagged last is accepted.
// Loading takes one word per cycle while busy is low; busy stays high until the final word is drained.
// Reset (synchronous, active high) empties the chain and clears the overflow flag.
// Results cannot be stalled: rsp_valid is a one-cycle strobe per word.
`default_nettype none

module insertion_sorter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire isort_pkg::req_type req_word,
   output logic                    rsp_valid,
   output isort_pkg::rsp_type      rsp_word
);
   import isort_pkg::*;

   // Chain control and contents.
   ctrl_type           ctrl;
   cell_type           cells [DEPTH];
   logic [DEPTH-1:0]   moves;

   state_type          state_ff, state_in;
   logic               dropped_ff, dropped_in;

   logic               accept;
   logic               full;
   logic               final_word;

   assign accept     = start && !busy;
   // Occupancy is a thermometer over the valid bits; the top cell marks full.
   assign full       = cells[DEPTH-1].valid;
   // Final result: next cell up is empty, so cell 0 holds the last key.
   assign final_word = !cells[1].valid;

   // Keys arriving on a full chain are dropped; the set still closes.
   assign ctrl.load  = accept && !full;
   assign ctrl.drain = (state_ff == ST_DRAIN);
   assign ctrl.key   = req_word.key;

   // Row of cells. Cell 0 always takes the new key when displaced;
   // the top cell pulls an empty slot in while draining.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_type prev_c;
      cell_type next_c;
      logic     prev_m;

      if (i == 0) begin : g_first
         assign prev_c = '0;
         assign prev_m = 1'b0;
      end else begin : g_mid
         assign prev_c = cells[i-1];
         assign prev_m = moves[i-1];
      end

      if (i == DEPTH-1) begin : g_top
         assign next_c = '0;
      end else begin : g_low
         assign next_c = cells[i+1];
      end

      isort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_cell (prev_c),
         .prev_move (prev_m),
         .next_cell (next_c),
         .slot      (cells[i]),
         .move      (moves[i])
      );
   end

   // Load until the last word, then drain cell 0 one word per cycle.
   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  dropped_in = 1'b1;
               end
               if (req_word.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (final_word) begin
               state_in   = ST_LOAD;
               dropped_in = 1'b0;  // next set starts clean
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   assign busy              = (state_ff == ST_DRAIN);
   assign rsp_valid         = (state_ff == ST_DRAIN);
   assign rsp_word.key_res  = cells[0].key;
   assign rsp_word.last_res = final_word;
   assign rsp_word.overflow = dropped_ff;

   // Closing a set always yields at least one result on the next cycle.
   a_close_emits: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.last) |=> rsp_valid)
      else $error("closing word not followed by a result");

   // Drain runs without gaps until the final word, then frees the input.
   a_drain_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last_res) |=> rsp_valid)
      else $error("gap inside a sorted run");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.last_res) |=> !busy)
      else $error("busy held after final result");

   // Output run is ascending.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last_res) |=>
         (rsp_word.key_res >= $past(rsp_word.key_res)))
      else $error("sorted run out of order");

   // Overflow flag is constant across one run.
   a_overflow_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.last_res) |=>
         (rsp_word.overflow == $past(rsp_word.overflow)))
      else $error("overflow flag changed within a run");

endmodule

`default_nettype wire
